>>> hw/rtl/assert_macros.svh
// ------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked property checks with an active-low reset that disables them.
// ------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside of reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising edge outside of reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/c2s_pkg.sv
// ------------------------------------------------------------------
// c2s_pkg
// Types, constants and helpers of the Cartesian to spherical converter.
// ------------------------------------------------------------------
package c2s_pkg;

	localparam int A_W     = 58;
	localparam int ANG_W   = 34;
	localparam int GUARD   = 20;
	localparam int TAB_LEN = 40;

	localparam logic [31:0] GAIN_Q30 = 32'd1768195363;
	localparam logic signed [ANG_W-1:0] HALF_PI_ANG = 34'sd1073741824;
	localparam logic signed [ANG_W-1:0] PI_ANG      = 34'sd2147483648;

	// round(atan(2^-i) * 2^31 / pi)
	localparam logic [31:0] ATAN_TABLE [TAB_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
	};

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} c2s_in_t;

	typedef struct packed {
		logic signed [32:0] longitude;
		logic signed [31:0] latitude;
		logic        [31:0] radius;
		logic               zero_vector;
	} c2s_out_t;

	typedef struct packed {
		logic x_pos;
		logic x_small;
		logic y_pos;
		logic y_neg;
		logic z_pos;
		logic z_neg;
		logic xy_zero;
		logic zero;
	} c2s_flags_t;

	typedef struct packed {
		logic signed [A_W-1:0]   a;
		logic signed [A_W-1:0]   b;
		logic signed [ANG_W-1:0] ang;
		logic signed [A_W-1:0]   zb;
		logic signed [32:0]      lon;
		logic        [63:0]      sq_rem;
		logic        [31:0]      sq_root;
		c2s_flags_t              flags;
	} c2s_data_t;

	function automatic logic signed [ANG_W-1:0] clamp_ang(
		input logic signed [ANG_W-1:0] ang,
		input logic                    pos
	);
		logic signed [ANG_W-1:0] r;
		r = ang;
		if (pos) begin
			if (ang < 0) r = '0;
			else if (ang > HALF_PI_ANG) r = HALF_PI_ANG;
		end else begin
			if (ang > 0) r = '0;
			else if (ang < -HALF_PI_ANG) r = -HALF_PI_ANG;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/cartesian_to_spherical.sv
// ------------------------------------------------------------------
// cartesian_to_spherical
// Converts a signed (x, y, z) vector into radius, latitude, longitude.
// ------------------------------------------------------------------
// Usage: an item on vec_data is taken when vec_valid and vec_ready are
// both high. Results leave on sph_data under sph_valid / sph_ready.
// Angles are binary fractions with 2^31 = pi. The radius is the rounded
// integer length of the vector.
// The datapath is one pipeline: two front stages, CORDIC_STAGES rotation
// cells for the longitude, one joint stage, CORDIC_STAGES cells for the
// latitude and the output register. The root digits run in the first
// 32 cells. Throughput is one item per cycle while the output is not
// stalled; every cell moves its item on to the next one each cycle that
// the pipeline advances.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and vec_ready drops in the same cycle; it rises again as soon as the
// result is taken.
// Reset clears all valid bits, sets band_q to 1. The user must write the
// band with band_we / band_wdata while no item is in flight, unenforced.
// ------------------------------------------------------------------
module cartesian_to_spherical import c2s_pkg::*; #(
	parameter int CORDIC_STAGES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vec_valid,
	output logic        vec_ready,
	input  c2s_in_t     vec_data,
	output logic        sph_valid,
	input  logic        sph_ready,
	output c2s_out_t    sph_data,
	input  logic        band_we,
	input  logic [15:0] band_wdata
);

	localparam int N = CORDIC_STAGES;

	logic        adv;
	logic [15:0] band_q;

	logic      v1 [N+1];
	c2s_data_t d1 [N+1];
	logic      v2 [N+1];
	c2s_data_t d2 [N+1];

	c2s_data_t fin;
	logic signed [ANG_W-1:0] lat;
	logic [31:0] rad;

	assign adv       = !sph_valid || sph_ready;
	assign vec_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= 16'd1;
		end else if (band_we) begin
			band_q <= band_wdata;
		end
	end

	c2s_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.up_valid (vec_valid),
		.up_data  (vec_data),
		.band     (band_q),
		.dn_valid (v1[0]),
		.dn_data  (d1[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_lon
		c2s_cell #(
			.SHIFT  (i),
			.SQ_BIT ((i < 32) ? 31 - i : -1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.up_valid (v1[i]),
			.up_data  (d1[i]),
			.dn_valid (v1[i+1]),
			.dn_data  (d1[i+1])
		);
	end

	c2s_joint u_joint (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.up_valid (v1[N]),
		.up_data  (d1[N]),
		.dn_valid (v2[0]),
		.dn_data  (d2[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_lat
		c2s_cell #(
			.SHIFT  (i),
			.SQ_BIT ((N + i < 32) ? 31 - (N + i) : -1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.up_valid (v2[i]),
			.up_data  (d2[i]),
			.dn_valid (v2[i+1]),
			.dn_data  (d2[i+1])
		);
	end

	assign fin = d2[N];

	always_comb begin
		if (!fin.flags.z_pos && !fin.flags.z_neg) begin
			lat = '0;
		end else if (fin.flags.xy_zero) begin
			lat = fin.flags.z_neg ? -HALF_PI_ANG : HALF_PI_ANG;
		end else begin
			lat = clamp_ang(fin.ang, fin.flags.z_pos);
		end
	end

	// Round to nearest: bump the root when the remainder exceeds it.
	assign rad = fin.sq_root + 32'(fin.sq_rem > {32'd0, fin.sq_root});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sph_valid <= 1'b0;
		end else if (adv) begin
			sph_valid <= v2[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sph_data.longitude   <= fin.lon;
			sph_data.latitude    <= lat[31:0];
			sph_data.radius      <= rad;
			sph_data.zero_vector <= fin.flags.zero;
		end
	end

endmodule

>>> hw/rtl/c2s_prep.sv
// ------------------------------------------------------------------
// c2s_prep
// Front end: magnitudes, squares, gain product, flags, then the sums.
// ------------------------------------------------------------------
module c2s_prep import c2s_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       up_valid,
	input  c2s_in_t    up_data,
	input  logic [15:0] band,
	output logic       dn_valid,
	output c2s_data_t  dn_data
);

	logic [31:0] ax, ay, az;
	logic        valid_s1;
	logic [63:0] sqx_s1, sqy_s1, sqz_s1, zprod_s1;
	logic signed [A_W-1:0] a_s1, b_s1;
	logic        z_neg_s1;
	c2s_flags_t  flags_s1;
	c2s_flags_t  flags_c;
	logic [63:0] zk;

	assign ax = up_data.vec_x[31] ? 32'(-up_data.vec_x) : up_data.vec_x;
	assign ay = up_data.vec_y[31] ? 32'(-up_data.vec_y) : up_data.vec_y;
	assign az = up_data.vec_z[31] ? 32'(-up_data.vec_z) : up_data.vec_z;

	always_comb begin
		flags_c.x_pos   = !up_data.vec_x[31] && (up_data.vec_x != 0);
		flags_c.x_small = (up_data.vec_x == 0) || (ax < {16'd0, band});
		flags_c.y_pos   = !up_data.vec_y[31] && (up_data.vec_y != 0);
		flags_c.y_neg   = up_data.vec_y[31];
		flags_c.z_pos   = !up_data.vec_z[31] && (up_data.vec_z != 0);
		flags_c.z_neg   = up_data.vec_z[31];
		flags_c.xy_zero = (up_data.vec_x == 0) && (up_data.vec_y == 0);
		flags_c.zero    = flags_c.xy_zero && (up_data.vec_z == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dn_valid <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
			dn_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1   <= ax * ax;
			sqy_s1   <= ay * ay;
			sqz_s1   <= az * az;
			zprod_s1 <= az * GAIN_Q30;
			a_s1     <= $signed({6'd0, ax, 20'd0});
			b_s1     <= A_W'(up_data.vec_y) <<< GUARD;
			z_neg_s1 <= up_data.vec_z[31];
			flags_s1 <= flags_c;
		end
	end

	// The gain product is rounded half up on the magnitude, then signed.
	assign zk = (zprod_s1 + 64'd512) >> 10;

	always_ff @(posedge clk) begin
		if (adv) begin
			dn_data.a       <= a_s1;
			dn_data.b       <= b_s1;
			dn_data.ang     <= '0;
			dn_data.zb      <= z_neg_s1 ? -$signed(A_W'(zk)) : $signed(A_W'(zk));
			dn_data.lon     <= '0;
			dn_data.sq_rem  <= sqx_s1 + sqy_s1 + sqz_s1;
			dn_data.sq_root <= '0;
			dn_data.flags   <= flags_s1;
		end
	end

endmodule

>>> hw/rtl/c2s_cell.sv
// ------------------------------------------------------------------
// c2s_cell
// One CORDIC micro-rotation, plus one root digit where SQ_BIT >= 0.
// ------------------------------------------------------------------
module c2s_cell import c2s_pkg::*; #(
	parameter int SHIFT  = 0,
	parameter int SQ_BIT = -1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      up_valid,
	input  c2s_data_t up_data,
	output logic      dn_valid,
	output c2s_data_t dn_data
);

	logic signed [A_W-1:0]   da, db;
	logic signed [ANG_W-1:0] step;
	logic [63:0] rem_n;
	logic [31:0] root_n;
	c2s_data_t   nxt;

	assign da   = up_data.b >>> SHIFT;
	assign db   = up_data.a >>> SHIFT;
	assign step = $signed({2'b00, ATAN_TABLE[SHIFT]});

	generate
		if (SQ_BIT >= 0) begin : g_sqrt
			logic [65:0] test;
			assign test = 66'({up_data.sq_root, 2'b01}) << (2 * SQ_BIT);
			always_comb begin
				if ({2'b00, up_data.sq_rem} >= test) begin
					rem_n  = up_data.sq_rem - test[63:0];
					root_n = {up_data.sq_root[30:0], 1'b1};
				end else begin
					rem_n  = up_data.sq_rem;
					root_n = {up_data.sq_root[30:0], 1'b0};
				end
			end
		end else begin : g_pass
			assign rem_n  = up_data.sq_rem;
			assign root_n = up_data.sq_root;
		end
	endgenerate

	always_comb begin
		nxt = up_data;
		if (!up_data.b[A_W-1]) begin
			nxt.a   = up_data.a + da;
			nxt.b   = up_data.b - db;
			nxt.ang = up_data.ang + step;
		end else begin
			nxt.a   = up_data.a - da;
			nxt.b   = up_data.b + db;
			nxt.ang = up_data.ang - step;
		end
		nxt.sq_rem  = rem_n;
		nxt.sq_root = root_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (adv) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn_data <= nxt;
		end
	end

endmodule

>>> hw/rtl/c2s_joint.sv
// ------------------------------------------------------------------
// c2s_joint
// Between the two rotation chains: longitude from the first angle and
// loading of the scaled z for the latitude rotation.
// ------------------------------------------------------------------
module c2s_joint import c2s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      up_valid,
	input  c2s_data_t up_data,
	output logic      dn_valid,
	output c2s_data_t dn_data
);

	logic signed [ANG_W-1:0] a1;
	logic signed [ANG_W-1:0] lon;
	c2s_flags_t f;
	c2s_data_t  nxt;

	assign f  = up_data.flags;
	assign a1 = clamp_ang(up_data.ang, f.y_pos);

	always_comb begin
		if (f.x_small) begin
			lon = f.y_neg ? -HALF_PI_ANG : HALF_PI_ANG;
		end else if (!f.y_pos && !f.y_neg) begin
			lon = f.x_pos ? '0 : PI_ANG;
		end else if (f.x_pos) begin
			lon = a1;
		end else if (f.y_pos) begin
			lon = PI_ANG - a1;
		end else begin
			lon = -PI_ANG - a1;
		end
	end

	always_comb begin
		nxt     = up_data;
		nxt.b   = up_data.zb;
		nxt.ang = '0;
		nxt.lon = lon[32:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (adv) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn_data <= nxt;
		end
	end

endmodule

>>> hw/rtl/c2s_checker.sv
// ------------------------------------------------------------------
// c2s_checker
// Port-level checks of the converter, bound to the top level.
// ------------------------------------------------------------------
`include "assert_macros.svh"

module c2s_checker import c2s_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        vec_valid,
	input logic        vec_ready,
	input c2s_in_t     vec_data,
	input logic        sph_valid,
	input logic        sph_ready,
	input c2s_out_t    sph_data,
	input logic        band_we,
	input logic [15:0] band_wdata
);

	`CHK_IMPLY(a_hold, clk, arst_n, sph_valid && !sph_ready, ##1 sph_valid, "result dropped while stalled")
	`CHK_IMPLY(a_ready, clk, arst_n, !sph_valid, vec_ready, "input stalled with empty output")
	`CHK_IMPLY(a_zero, clk, arst_n, sph_valid && sph_data.zero_vector, (sph_data.latitude == 0) && (sph_data.radius == 0), "zero vector result not zero")
	`CHK_IMPLY(a_lat, clk, arst_n, sph_valid, (sph_data.latitude >= -32'sd1073741824) && (sph_data.latitude <= 32'sd1073741824), "latitude out of range")
	`CHK_IMPLY(a_lon, clk, arst_n, sph_valid, (sph_data.longitude >= -33'sd2147483648) && (sph_data.longitude <= 33'sd2147483648), "longitude out of range")

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);
